// ----- rtl/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared constants, types and helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 9;
  localparam int CODE_W  = 2;
  localparam int PHASE_W = 2;
  localparam int HEXC_W  = 2;

  localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BODY = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SUM  = 2'd2;

  localparam logic [CODE_W-1:0] FAIL_OK       = 2'd0;
  localparam logic [CODE_W-1:0] FAIL_MISMATCH = 2'd1;
  localparam logic [CODE_W-1:0] FAIL_NO_STAR  = 2'd2;
  localparam logic [CODE_W-1:0] FAIL_OVERFLOW = 2'd3;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;

  localparam logic [BYTE_W-1:0] SUM_DEFAULT    = 8'h55;
  localparam logic [LEN_W-1:0]  BODY_LEN_RESET = 9'd298;
  localparam logic [LEN_W-1:0]  COUNT_MAX      = 9'h1FF;
  localparam logic [HEXC_W-1:0] HEX_DONE       = 2'd2;

  typedef struct packed {
    logic              line_ok;
    logic [CODE_W-1:0] fail_code;
    logic [BYTE_W-1:0] computed_sum;
  } nsc_result_t;

  // {digit valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- rtl/nsc_stream_if.sv -----
// ----------------------------------------------------------------------------
// nsc_stream_if
// Valid/ready channels: received bytes in, sentence verdicts out.
// ----------------------------------------------------------------------------
interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface nsc_verdict_if;
  logic       valid;
  logic       ready;
  logic       line_ok;
  logic [1:0] fail_code;
  logic [7:0] computed_sum;

  modport source(output valid, output line_ok, output fail_code, output computed_sum,
                 input ready);
  modport sink(input valid, input line_ok, input fail_code, input computed_sum,
               output ready);
endinterface

// ----- rtl/nmea_sentence_checker.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Frames '$'...'*hh' LF sentences in a byte stream and checks the XOR sum.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  rx        in   valid/ready        rx_byte[7:0]
//  verdict   out  valid/ready        line_ok, fail_code[1:0], computed_sum[7:0]
//  cfg       in   cfg_wr_en          cfg_wr_data[8:0] = max_body_len
//
//  One byte per cycle while the verdict channel is not stalled; a verdict is
//  registered after its closing byte (input register, then result register).
//  Throughput is set by the single framer update per cycle.
//  Synchronous reset clears the framer and both stage valid flags;
//  max_body_len -> 298.
//  A stalled verdict holds; rx keeps accepting until the input register fills.
// ----------------------------------------------------------------------------
module nmea_sentence_checker import nsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  nsc_byte_if.sink         rx,
  nsc_verdict_if.source    verdict,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic [LEN_W-1:0]  max_body_len;
  logic              advance;
  logic              step;
  logic              res_valid;
  nsc_result_t       res;

  assign step     = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len <= BODY_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_body_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  nsc_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (in_byte),
    .max_body_len (max_body_len),
    .res_valid    (res_valid),
    .res          (res)
  );

  nsc_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .d_valid (res_valid),
    .d       (res),
    .advance (advance),
    .verdict (verdict)
  );

endmodule

// ----- rtl/nsc_framer.sv -----
// ----------------------------------------------------------------------------
// nsc_framer
// Sentence state and per-byte next-state logic; emits at most one verdict.
// ----------------------------------------------------------------------------
module nsc_framer import nsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [LEN_W-1:0]  max_body_len,
  output logic              res_valid,
  output nsc_result_t       res
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [BYTE_W-1:0]  running_xor, running_xor_next;
  logic [BYTE_W-1:0]  expected_sum, expected_sum_next;
  logic [HEXC_W-1:0]  hex_seen, hex_seen_next;
  logic [LEN_W-1:0]   body_count, body_count_next;
  logic               no_star, no_star_next;
  logic [CODE_W-1:0]  code;
  logic [4:0]         hd;

  assign hd = hex_digit(rx_byte);

  always_comb begin
    phase_next        = phase;
    running_xor_next  = running_xor;
    expected_sum_next = expected_sum;
    hex_seen_next     = hex_seen;
    body_count_next   = body_count;
    no_star_next      = no_star;
    res_valid         = 1'b0;
    code              = FAIL_OK;
    if (step) begin
      if (phase != PH_BODY && phase != PH_SUM) begin
        if (rx_byte == CH_DOLLAR) begin
          phase_next        = PH_BODY;
          running_xor_next  = '0;
          expected_sum_next = SUM_DEFAULT;
          hex_seen_next     = '0;
          body_count_next   = '0;
          no_star_next      = 1'b0;
        end else begin
          phase_next = PH_HUNT;
        end
      end else begin
        if (body_count != COUNT_MAX) begin
          body_count_next = body_count + 1'b1;
        end
        if (rx_byte == CH_LF) begin
          res_valid  = 1'b1;
          phase_next = PH_HUNT;
          if (phase == PH_BODY) begin
            code = FAIL_NO_STAR;
          end else begin
            code = (running_xor == expected_sum) ? FAIL_OK : FAIL_MISMATCH;
          end
        end else begin
          if (phase == PH_BODY) begin
            if (!no_star) begin
              if (rx_byte == CH_NUL || rx_byte == CH_CR) begin
                no_star_next = 1'b1;
              end else if (rx_byte == CH_STAR) begin
                phase_next = PH_SUM;
              end else begin
                running_xor_next = running_xor ^ rx_byte;
              end
            end
          end else if (hex_seen < HEX_DONE) begin
            if (!hd[4]) begin
              hex_seen_next = HEX_DONE;
            end else begin
              expected_sum_next = (hex_seen == '0) ? {4'd0, hd[3:0]}
                                                   : {expected_sum[3:0], hd[3:0]};
              hex_seen_next     = hex_seen + 1'b1;
            end
          end
          if (body_count_next >= max_body_len) begin
            res_valid  = 1'b1;
            code       = FAIL_OVERFLOW;
            phase_next = PH_HUNT;
          end
        end
      end
    end
    res.line_ok      = (code == FAIL_OK);
    res.fail_code    = code;
    res.computed_sum = running_xor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      running_xor  <= '0;
      expected_sum <= SUM_DEFAULT;
      hex_seen     <= '0;
      body_count   <= '0;
      no_star      <= 1'b0;
    end else begin
      phase        <= phase_next;
      running_xor  <= running_xor_next;
      expected_sum <= expected_sum_next;
      hex_seen     <= hex_seen_next;
      body_count   <= body_count_next;
      no_star      <= no_star_next;
    end
  end

endmodule

// ----- rtl/nsc_out_reg.sv -----
// ----------------------------------------------------------------------------
// nsc_out_reg
// Result register driving the verdict channel; holds while the sink stalls.
// ----------------------------------------------------------------------------
module nsc_out_reg import nsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 d_valid,
  input  nsc_result_t          d,
  output logic                 advance,
  nsc_verdict_if.source        verdict
);

  logic        valid;
  nsc_result_t data;

  assign advance = !valid || verdict.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && d_valid) begin
      data <= d;
    end
  end

  assign verdict.valid        = valid;
  assign verdict.line_ok      = data.line_ok;
  assign verdict.fail_code    = data.fail_code;
  assign verdict.computed_sum = data.computed_sum;

endmodule

// ----- rtl/nsc_checker.sv -----
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks for the sentence checker, bound to the top level.
// ----------------------------------------------------------------------------
module nsc_checker import nsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rx_ready,
  input logic              v_valid,
  input logic              v_ready,
  input logic              line_ok,
  input logic [CODE_W-1:0] fail_code,
  input logic [BYTE_W-1:0] computed_sum
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v_valid && !v_ready |=> v_valid && $stable(line_ok) && $stable(fail_code)
                            && $stable(computed_sum))
    else $error("verdict changed while stalled");

  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    v_valid |-> line_ok == (fail_code == FAIL_OK))
    else $error("line_ok disagrees with fail_code");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !v_valid)
    else $error("verdict valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> v_valid && !v_ready)
    else $error("rx stalled without a pending verdict");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_ready     (rx.ready),
  .v_valid      (verdict.valid),
  .v_ready      (verdict.ready),
  .line_ok      (verdict.line_ok),
  .fail_code    (verdict.fail_code),
  .computed_sum (verdict.computed_sum)
);
